>>> hdl/cf4_pkg.sv
// ----------------------------------------------------------------------------
// cf4_pkg
// shared types and constants for the segmented character map lookup
// ----------------------------------------------------------------------------
package cf4_pkg;

    // field widths
    localparam int CMD_W     = 2;
    localparam int CNT_W     = 9;
    localparam int SEG_IDX_W = 8;
    localparam int CODE_W    = 16;
    localparam int WADDR_W   = 12;
    localparam int CP_W      = 21;
    localparam int GADDR_W   = 18;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // default sizes
    localparam int DEF_MAX_SEGMENTS = 256;
    localparam int DEF_WORD_DEPTH   = 4096;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_SEG  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_WORD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd2;

    // kind of result written to the output register
    typedef enum logic [1:0] {
        RES_MISS,
        RES_OOB,
        RES_DIRECT,
        RES_WORD
    } t_res_kind;

    // one segment store entry
    typedef struct packed {
        logic [CODE_W-1:0] delta;
        logic [CODE_W-1:0] start;
        logic [CODE_W-1:0] last;
    } t_seg_entry;

    // controller to datapath
    typedef struct packed {
        logic      load_seg;
        logic      load_word;
        logic      start_lookup;
        logic      scan_en;
        logic      word_rd_ofs;
        logic      calc_gaddr;
        logic      word_rd_gly;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cp_big;
        logic hit;
        logic scan_end;
        logic below_start;
        logic idx_oob;
        logic ofs_zero;
        logic gaddr_oob;
        logic word_zero;
    } t_dp_status;

endpackage

>>> hdl/cf4_ctrl.sv
// ----------------------------------------------------------------------------
// cf4_ctrl
// lookup sequencer: scan, offset read, glyph read, result hand-off
// ----------------------------------------------------------------------------
module cf4_ctrl
    import cf4_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_vld,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_rdy,
    output t_dp_cmd          o_cmd,
    input  t_dp_status       i_sts,
    output logic             o_out_vld,
    input  logic             i_out_rdy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEG,
        ST_OFS,
        ST_GADDR,
        ST_GLY
    } t_state;

    t_state    r_state;
    t_state    n_state;
    logic      r_out_vld;
    logic      out_free;
    logic      accept;
    logic      decide;
    t_res_kind kind;

    assign out_free  = !r_out_vld || i_out_rdy;
    assign o_in_rdy  = (r_state == ST_IDLE);
    assign accept    = i_in_vld && o_in_rdy;
    assign o_out_vld = r_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        decide  = 1'b0;
        kind    = RES_MISS;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_in_cmd == CMD_LOAD_SEG) begin
                        o_cmd.load_seg = 1'b1;
                    end else if (i_in_cmd == CMD_LOAD_WORD) begin
                        o_cmd.load_word = 1'b1;
                    end else if (i_in_cmd == CMD_LOOKUP) begin
                        o_cmd.start_lookup = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                priority if (i_sts.cp_big) begin
                    decide = 1'b1;
                end else if (i_sts.hit) begin
                    n_state = ST_SEG;
                end else if (i_sts.scan_end) begin
                    decide = 1'b1;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SEG: begin
                priority if (i_sts.below_start) begin
                    decide = 1'b1;
                end else if (i_sts.idx_oob) begin
                    decide = 1'b1;
                    kind   = RES_OOB;
                end else begin
                    o_cmd.word_rd_ofs = 1'b1;
                    n_state = ST_OFS;
                end
            end
            ST_OFS: begin
                if (i_sts.ofs_zero) begin
                    decide = 1'b1;
                    kind   = RES_DIRECT;
                end else begin
                    o_cmd.calc_gaddr = 1'b1;
                    n_state = ST_GADDR;
                end
            end
            ST_GADDR: begin
                if (i_sts.gaddr_oob) begin
                    decide = 1'b1;
                    kind   = RES_OOB;
                end else begin
                    o_cmd.word_rd_gly = 1'b1;
                    n_state = ST_GLY;
                end
            end
            ST_GLY: begin
                decide = 1'b1;
                kind   = i_sts.word_zero ? RES_MISS : RES_WORD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // hold in the deciding state until the output slot frees up
        o_cmd.res_kind = kind;
        if (decide && out_free) begin
            o_cmd.res_load = 1'b1;
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/cf4_datapath.sv
// ----------------------------------------------------------------------------
// cf4_datapath
// segment store, word store, scan pipeline and result register
// ----------------------------------------------------------------------------
module cf4_datapath
    import cf4_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int WORD_DEPTH   = DEF_WORD_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_W-1:0]     i_cfg_wr_data,
    input  logic [SEG_IDX_W-1:0] i_segment_index,
    input  logic [CODE_W-1:0]    i_seg_end,
    input  logic [CODE_W-1:0]    i_seg_start,
    input  logic [CODE_W-1:0]    i_seg_delta,
    input  logic [WADDR_W-1:0]   i_word_address,
    input  logic [CODE_W-1:0]    i_word_value,
    input  logic [CP_W-1:0]      i_char_code,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_sts,
    output logic                 o_found,
    output logic [CODE_W-1:0]    o_glyph_index,
    output logic                 o_out_of_bounds
);

    localparam int SA = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int WA = $clog2(WORD_DEPTH);

    t_seg_entry        seg_mem [MAX_SEGMENTS];
    logic [CODE_W-1:0] word_mem [WORD_DEPTH];

    logic [CNT_W-1:0]   r_seg_count;
    logic [CNT_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_q_idx;
    logic               r_q_vld;
    logic [CODE_W-1:0]  r_cp;
    logic               r_cp_big;
    t_seg_entry         r_seg_q;
    logic [CODE_W-1:0]  r_word_q;
    logic [GADDR_W-1:0] r_gaddr;
    logic               r_found;
    logic [CODE_W-1:0]  r_glyph;
    logic               r_oob;

    logic [CNT_W-1:0]   limit_clamped;
    logic               seg_wr_ok;
    logic               word_wr_ok;
    logic               scan_issue;
    logic [WA-1:0]      word_rd_addr;
    logic [CODE_W-1:0]  glyph_next;

    assign limit_clamped = (32'(r_seg_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                             : r_seg_count;
    assign seg_wr_ok  = 32'(i_segment_index) < MAX_SEGMENTS;
    assign word_wr_ok = 32'(i_word_address) < WORD_DEPTH;

    // one segment read per cycle, stop as soon as a deciding segment shows up
    assign scan_issue = i_cmd.scan_en && !r_cp_big && !o_sts.hit && (r_idx < r_limit);

    assign word_rd_addr = i_cmd.word_rd_ofs ? WA'(r_q_idx) : r_gaddr[WA-1:0];

    always_comb begin
        o_sts             = '0;
        o_sts.cp_big      = r_cp_big;
        o_sts.hit         = r_q_vld && (r_seg_q.last >= r_cp);
        o_sts.scan_end    = !r_q_vld && (r_idx >= r_limit);
        o_sts.below_start = r_cp < r_seg_q.start;
        o_sts.idx_oob     = 32'(r_q_idx) >= WORD_DEPTH;
        o_sts.ofs_zero    = (r_word_q == '0);
        o_sts.gaddr_oob   = 32'(r_gaddr) >= WORD_DEPTH;
        o_sts.word_zero   = (r_word_q == '0);
    end

    always_comb begin
        unique case (i_cmd.res_kind)
            RES_DIRECT: glyph_next = r_seg_q.delta + r_cp;
            RES_WORD:   glyph_next = r_word_q + r_seg_q.delta;
            default:    glyph_next = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
            r_q_vld     <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seg_count <= i_cfg_wr_data;
            end
            if (i_cmd.start_lookup) begin
                r_idx   <= '0;
                r_q_vld <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_q_vld <= scan_issue;
                if (scan_issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
        end
    end

    // lookup operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_lookup) begin
            r_cp     <= i_char_code[CODE_W-1:0];
            r_cp_big <= |i_char_code[CP_W-1:CODE_W];
            r_limit  <= limit_clamped;
        end
        if (scan_issue) begin
            r_q_idx <= r_idx;
        end
        if (i_cmd.calc_gaddr) begin
            r_gaddr <= GADDR_W'(r_q_idx) + GADDR_W'(r_word_q[CODE_W-1:1])
                     + GADDR_W'(r_cp - r_seg_q.start);
        end
        if (i_cmd.res_load) begin
            r_found <= (i_cmd.res_kind == RES_DIRECT) || (i_cmd.res_kind == RES_WORD);
            r_oob   <= (i_cmd.res_kind == RES_OOB);
            r_glyph <= glyph_next;
        end
    end

    // segment store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seg && seg_wr_ok) begin
            seg_mem[SA'(i_segment_index)] <= '{delta: i_seg_delta, start: i_seg_start,
                                               last: i_seg_end};
        end
        if (scan_issue) begin
            r_seg_q <= seg_mem[SA'(r_idx)];
        end
    end

    // word store: range offsets then glyph words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word && word_wr_ok) begin
            word_mem[WA'(i_word_address)] <= i_word_value;
        end
        if (i_cmd.word_rd_ofs || i_cmd.word_rd_gly) begin
            r_word_q <= word_mem[word_rd_addr];
        end
    end

    assign o_found         = r_found;
    assign o_glyph_index   = r_glyph;
    assign o_out_of_bounds = r_oob;

endmodule

>>> hdl/cmap_format4_glyph_lookup_top.sv
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_top
// code point to glyph index lookup over a segmented character map
// ----------------------------------------------------------------------------
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tuser: command, tdata: load and lookup fields
// m_axis    out  m_axis_tvalid/tready    tuser: found, out_of_bounds, tdata: glyph_index
// cfg       in   i_cfg_wr_en             i_cfg_wr_data: segments to scan
//
// a load beat is written as it is accepted and leaves the sequencer idle; a lookup
// above the code range decides without scanning, one with no deciding segment
// decides once the scan ends, and one with a deciding segment goes on from there
// the segment scan reads one segment store entry per cycle, then the word
// store's single read port serves the range offset and the glyph word in turn
// reset is synchronous, active low; store contents are not cleared
// a new beat is taken as soon as the sequencer is idle, even while a result
// waits in the output register; a finished lookup holds until that slot frees
//
module cmap_format4_glyph_lookup_top
    import cf4_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int WORD_DEPTH   = DEF_WORD_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_W-1:0]     i_cfg_wr_data,    // segments to scan
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CMD_W-1:0]     s_axis_tuser,     // command
    // segment_index, seg_end, seg_start, seg_delta, word_address, word_value,
    // char_code, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TUSER_W-1:0] m_axis_tuser,     // found, out_of_bounds
    output logic [M_TDATA_W-1:0] m_axis_tdata      // glyph_index
);

    t_dp_cmd     cmd;
    t_dp_status  sts;
    logic        found;
    logic        oob;

    // unpack the input beat, lowest field first
    logic [SEG_IDX_W-1:0] segment_index;
    logic [CODE_W-1:0]    seg_end;
    logic [CODE_W-1:0]    seg_start;
    logic [CODE_W-1:0]    seg_delta;
    logic [WADDR_W-1:0]   word_address;
    logic [CODE_W-1:0]    word_value;
    logic [CP_W-1:0]      char_code;

    assign segment_index = s_axis_tdata[7:0];
    assign seg_end       = s_axis_tdata[23:8];
    assign seg_start     = s_axis_tdata[39:24];
    assign seg_delta     = s_axis_tdata[55:40];
    assign word_address  = s_axis_tdata[67:56];
    assign word_value    = s_axis_tdata[83:68];
    assign char_code     = s_axis_tdata[104:84];

    cf4_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .i_in_cmd  (s_axis_tuser),
        .o_in_rdy  (s_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts),
        .o_out_vld (m_axis_tvalid),
        .i_out_rdy (m_axis_tready)
    );

    cf4_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .WORD_DEPTH   (WORD_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_segment_index (segment_index),
        .i_seg_end       (seg_end),
        .i_seg_start     (seg_start),
        .i_seg_delta     (seg_delta),
        .i_word_address  (word_address),
        .i_word_value    (word_value),
        .i_char_code     (char_code),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found         (found),
        .o_glyph_index   (m_axis_tdata),
        .o_out_of_bounds (oob)
    );

    assign m_axis_tuser = {oob, found};

endmodule

>>> test/cmap_format4_glyph_lookup_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_top_tb
// self-checking bench for the segmented character map glyph lookup
// ----------------------------------------------------------------------------
// builds a well-formed segment map through load beats, then fires lookups at
// segment edges, gaps and random code points under several segment totals,
// mixed with stray loads and unused commands. a live copy of both stores, fed by
// accepted beats, predicts every lookup at the moment its beat is accepted; results are
// checked in order, field by field.
// the segment count is changed only once the block has gone quiet.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup_top_tb;
    import cf4_pkg::*;

    localparam int N_SEG         = DEF_MAX_SEGMENTS;
    localparam int N_WORD        = DEF_WORD_DEPTH;
    localparam int CODE_SPAN     = 65536;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_BEATS   = 25;
    // store copies: the one the stimulus is planned against, the one fed by accepted beats
    localparam int SHADOW        = 0;
    localparam int LIVE          = 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [SEG_IDX_W-1:0] seg_idx;
        logic [CODE_W-1:0]    seg_end;
        logic [CODE_W-1:0]    seg_start;
        logic [CODE_W-1:0]    seg_delta;
        logic [WADDR_W-1:0]   word_addr;
        logic [CODE_W-1:0]    word_val;
        logic [CP_W-1:0]      code_pt;
    } t_cmap_beat;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] glyph;
        logic              oob;
    } t_glyph_res;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wr_data  = '0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [CMD_W-1:0]     s_axis_tuser   = '0;   // command
    // segment_index, seg_end, seg_start, seg_delta, word_address, word_value,
    // char_code, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [M_TUSER_W-1:0] m_axis_tuser;          // found, out_of_bounds
    logic [M_TDATA_W-1:0] m_axis_tdata;          // glyph_index

    cmap_format4_glyph_lookup_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // two copies of the character map state
    bit [CODE_W-1:0] seg_end_mem   [2][N_SEG];
    bit [CODE_W-1:0] seg_start_mem [2][N_SEG];
    bit [CODE_W-1:0] seg_delta_mem [2][N_SEG];
    bit              seg_loaded    [2][N_SEG];
    bit [CODE_W-1:0] word_mem      [2][N_WORD];
    bit              word_loaded   [2][N_WORD];
    int              seg_count_cfg [2];

    t_cmap_beat pending_beats [$];
    t_glyph_res glyphs_due    [$];
    int         glyph_mismatches = 0;
    int         quiet_cycles     = 0;

    // first deciding segment wins; blank flags a read of a never-loaded entry
    function automatic t_glyph_res map_char_code(input int side, input logic [CP_W-1:0] cp,
                                                 output bit blank);
        int              lim;
        int              seg;
        int unsigned     gaddr;
        bit [CODE_W-1:0] ofs;
        bit [CODE_W-1:0] gword;
        t_glyph_res      res;
        res   = '0;
        blank = 1'b0;
        lim   = (seg_count_cfg[side] > N_SEG) ? N_SEG : seg_count_cfg[side];
        if (cp >= CODE_SPAN) return res;
        for (seg = 0; seg < lim; seg++) begin
            if (!seg_loaded[side][seg]) blank = 1'b1;
            if (seg_end_mem[side][seg] < cp) continue;
            if (cp < seg_start_mem[side][seg]) return res;
            if (!word_loaded[side][seg]) blank = 1'b1;
            ofs = word_mem[side][seg];
            if (ofs == '0) begin
                res.found = 1'b1;
                res.glyph = seg_delta_mem[side][seg] + cp[CODE_W-1:0];
                return res;
            end
            gaddr = seg + (ofs >> 1) + (cp - seg_start_mem[side][seg]);
            if (gaddr >= N_WORD) begin
                res.oob = 1'b1;
                return res;
            end
            if (!word_loaded[side][gaddr]) blank = 1'b1;
            gword = word_mem[side][gaddr];
            if (gword == '0) return res;
            res.found = 1'b1;
            res.glyph = gword + seg_delta_mem[side][seg];
            return res;
        end
        return res;
    endfunction

    function automatic void apply_cmap_beat(input int side, input t_cmap_beat b,
                                            output bit has_res, output t_glyph_res res,
                                            output bit blank);
        has_res = 1'b0;
        res     = '0;
        blank   = 1'b0;
        case (b.cmd)
            CMD_LOAD_SEG: begin
                if (b.seg_idx < N_SEG) begin
                    seg_end_mem[side][b.seg_idx]   = b.seg_end;
                    seg_start_mem[side][b.seg_idx] = b.seg_start;
                    seg_delta_mem[side][b.seg_idx] = b.seg_delta;
                    seg_loaded[side][b.seg_idx]    = 1'b1;
                end
            end
            CMD_LOAD_WORD: begin
                if (b.word_addr < N_WORD) begin
                    word_mem[side][b.word_addr]    = b.word_val;
                    word_loaded[side][b.word_addr] = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                has_res = 1'b1;
                res     = map_char_code(side, b.code_pt, blank);
            end
            default: ;
        endcase
    endfunction

    // fields a command does not use are left random
    function automatic t_cmap_beat random_beat(input logic [CMD_W-1:0] cmd);
        t_cmap_beat b;
        b.cmd       = cmd;
        b.seg_idx   = SEG_IDX_W'($urandom);
        b.seg_end   = CODE_W'($urandom);
        b.seg_start = CODE_W'($urandom);
        b.seg_delta = CODE_W'($urandom);
        b.word_addr = WADDR_W'($urandom);
        b.word_val  = CODE_W'($urandom);
        b.code_pt   = CP_W'($urandom);
        return b;
    endfunction

    // a lookup that would touch a never-loaded entry is moved above the code range
    task automatic push_beat(input t_cmap_beat b);
        bit         has;
        bit         blank;
        t_glyph_res r;
        if (b.cmd == CMD_LOOKUP) begin
            r = map_char_code(SHADOW, b.code_pt, blank);
            if (blank) b.code_pt = CP_W'($urandom_range(CODE_SPAN, 21'h1FFFFF));
        end
        apply_cmap_beat(SHADOW, b, has, r, blank);
        pending_beats.push_back(b);
    endtask

    task automatic push_seg(input int idx, input int hi, input int lo, input int delta);
        t_cmap_beat b;
        b           = random_beat(CMD_LOAD_SEG);
        b.seg_idx   = SEG_IDX_W'(idx);
        b.seg_end   = CODE_W'(hi);
        b.seg_start = CODE_W'(lo);
        b.seg_delta = CODE_W'(delta);
        push_beat(b);
    endtask

    task automatic push_word(input int addr, input int val);
        t_cmap_beat b;
        b           = random_beat(CMD_LOAD_WORD);
        b.word_addr = WADDR_W'(addr);
        b.word_val  = CODE_W'(val);
        push_beat(b);
    endtask

    task automatic push_lookup(input int cp);
        t_cmap_beat b;
        b         = random_beat(CMD_LOOKUP);
        b.code_pt = CP_W'(cp);
        push_beat(b);
    endtask

    // code points aimed at segment interiors, edges and the gaps next to them
    function automatic int pick_char_code();
        int lim;
        int s;
        int lo;
        int hi;
        int sel;
        lim = (seg_count_cfg[SHADOW] > N_SEG) ? N_SEG : seg_count_cfg[SHADOW];
        sel = $urandom_range(0, 9);
        if (lim == 0 || sel == 9) return $urandom_range(0, 21'h1FFFFF);
        if (sel == 8) return $urandom_range(0, CODE_SPAN - 1);
        s  = $urandom_range(0, lim - 1);
        lo = int'(seg_start_mem[SHADOW][s]);
        hi = int'(seg_end_mem[SHADOW][s]);
        if (lo > hi) return lo;
        if (sel <= 5) return $urandom_range(lo, hi);
        if (sel == 6) return $urandom_range(0, 1) ? lo : hi;
        if ($urandom_range(0, 1) && lo > 0) return lo - 1;
        return hi + 1;
    endfunction

    // ascending segments, each either direct, through the glyph array, or
    // with a range offset that can run past the word store
    task automatic build_map(input int nseg);
        int              i;
        int              k;
        int              code;
        int              span;
        int              len;
        int              gap;
        int              lo;
        int              hi;
        int              g;
        int              kind;
        logic [CODE_W-1:0] ofs;
        g    = N_SEG;
        code = $urandom_range(0, 64);
        for (i = 0; i < nseg; i++) begin
            span = (CODE_SPAN - code) / (nseg - i);
            len  = $urandom_range(1, (span < 4) ? span : 4);
            gap  = $urandom_range(0, span - len);
            lo   = code + gap;
            hi   = lo + len - 1;
            code = hi + 1;
            if (i == nseg - 1 && $urandom_range(0, 1)) begin
                lo  = CODE_SPAN - 1;
                hi  = CODE_SPAN - 1;
                len = 1;
            end
            kind = $urandom_range(0, 9);
            if (kind >= 7 && kind <= 8 && g + len <= N_WORD) begin
                ofs = CODE_W'(2 * (g - i) + $urandom_range(0, 1));
                for (k = 0; k < len; k++)
                    push_word(g + k, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 65535));
                g += len;
            end else if (kind == 9) begin
                ofs = $urandom_range(0, 1) ? 16'hFFFE
                                           : CODE_W'(2 * (N_WORD - i - $urandom_range(0, len - 1)));
            end else begin
                ofs = '0;
            end
            push_seg(i, hi, lo, $urandom_range(0, 65535));
            push_word(i, ofs);
        end
    endtask

    task automatic random_traffic(input int n);
        int done;
        int sel;
        done = 0;
        while (done < n) begin
            sel = $urandom_range(0, 19);
            if (sel < 17) begin
                push_lookup(pick_char_code());
                done++;
            end else if (sel == 17) begin
                push_seg($urandom_range(0, N_SEG - 1), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
                done++;
            end else if (sel == 18) begin
                push_word($urandom_range(0, N_WORD - 1), $urandom_range(0, 65535));
                done++;
            end else begin
                push_beat(random_beat(CMD_UNUSED));
            end
        end
    endtask

    // stimulus waits until every beat is in and every result is out
    task automatic drain();
        while (pending_beats.size() != 0 || s_axis_tvalid || glyphs_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seg_count(input int cnt);
        drain();
        @(posedge i_clk);
        i_cfg_wr_en           <= 1'b1;
        i_cfg_wr_data         <= CNT_W'(cnt);
        seg_count_cfg[SHADOW]  = cnt;
        seg_count_cfg[LIVE]    = cnt;
        @(posedge i_clk);
        i_cfg_wr_en           <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         p;
        int         cnt;
        int         phase_counts [6];
        t_cmap_beat b;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty map: nothing decides, code point above range
        write_seg_count(0);
        push_lookup(0);
        push_lookup(21'h1FFFFF);
        b = '{CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1};
        push_beat(b);

        // small hand-built map
        write_seg_count(4);
        push_seg(0, 16'h0040, 16'h0020, 16'h0010);
        push_word(0, 0);
        push_seg(1, 16'h0100, 16'h0080, 16'hFFF0);
        push_word(1, 2 * (16'h0300 - 1));
        push_word(16'h0300, 16'h1234);
        push_word(16'h0301, 16'h0000);
        push_word(16'h0302, 16'hFFFF);
        push_seg(2, 16'h2000, 16'h1000, 16'h0005);
        push_word(2, 16'hFFFE);
        push_seg(3, 16'h8000, 16'h7FFF, 16'hFFFF);
        push_word(3, 0);
        push_word(N_WORD - 1, 16'hFFFF);
        push_lookup(16'h0020);    // direct hit
        push_lookup(16'h0010);    // below the first start
        push_lookup(16'h0050);    // gap before a segment
        push_lookup(16'h0080);    // glyph word plus delta
        push_lookup(16'h0081);    // zero glyph word
        push_lookup(16'h0082);    // glyph word wraps
        push_lookup(16'h1800);    // glyph address past the store
        push_lookup(16'h8000);    // direct with wrap
        push_lookup(16'hFFFF);    // no deciding segment
        push_lookup(CODE_SPAN);   // first code above range

        phase_counts = '{256, 511, 1, 255, $urandom_range(2, 200), 128};
        for (p = 0; p < 6; p++) begin
            cnt = phase_counts[p];
            write_seg_count(cnt);
            // one full map, later phases scan prefixes of it
            if (p == 0) build_map(N_SEG);
            random_traffic(PHASE_BEATS);
        end

        drain();
        if (glyph_mismatches == 0 && glyphs_due.size() == 0) begin
            $display("cmap_format4_glyph_lookup_top: match");
        end else begin
            $display("cmap_format4_glyph_lookup_top: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left   = 0;
    t_cmap_beat drv_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                drv_beat = pending_beats.pop_front();
                s_axis_tuser  <= drv_beat.cmd;
                s_axis_tdata  <= {7'd0, drv_beat.code_pt, drv_beat.word_val,
                                  drv_beat.word_addr, drv_beat.seg_delta,
                                  drv_beat.seg_start, drv_beat.seg_end, drv_beat.seg_idx};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: always ready, sparse stalls, or long stall runs
    // ------------------------------------------------------------------------
    int rdy_mode   = 0;
    int rdy_left   = 0;
    int stall_left = 0;
    bit rdy_next;

    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(50, 300);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: rdy_next = 1'b1;
            1: rdy_next = ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    rdy_next = 1'b0;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 20);
                    rdy_next   = 1'b0;
                end else begin
                    rdy_next = 1'b1;
                end
            end
        endcase
        m_axis_tready <= rdy_next;
    end

    // ------------------------------------------------------------------------
    // monitor: predict on accepted beats, check results in order
    // ------------------------------------------------------------------------
    t_cmap_beat acc_beat;
    t_glyph_res acc_res;
    t_glyph_res want;
    t_glyph_res got;
    bit         acc_has;
    bit         acc_blank;

    task automatic note_mismatch(input string what, input t_glyph_res exp_r,
                                 input t_glyph_res got_r);
        if (glyph_mismatches < 10)
            $display("%s: expected found=%0d glyph=%h oob=%0d, got found=%0d glyph=%h oob=%0d",
                     what, exp_r.found, exp_r.glyph, exp_r.oob,
                     got_r.found, got_r.glyph, got_r.oob);
        glyph_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc_beat.cmd       = s_axis_tuser;
                acc_beat.seg_idx   = s_axis_tdata[7:0];
                acc_beat.seg_end   = s_axis_tdata[23:8];
                acc_beat.seg_start = s_axis_tdata[39:24];
                acc_beat.seg_delta = s_axis_tdata[55:40];
                acc_beat.word_addr = s_axis_tdata[67:56];
                acc_beat.word_val  = s_axis_tdata[83:68];
                acc_beat.code_pt   = s_axis_tdata[104:84];
                apply_cmap_beat(LIVE, acc_beat, acc_has, acc_res, acc_blank);
                if (acc_has) glyphs_due.push_back(acc_res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tuser[0];
                got.oob   = m_axis_tuser[1];
                got.glyph = m_axis_tdata;
                if (glyphs_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = glyphs_due.pop_front();
                    if (got.found !== want.found || got.glyph !== want.glyph ||
                        got.oob !== want.oob)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // watchdog: no beat moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("cmap_format4_glyph_lookup_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> filelist.f
hdl/cf4_pkg.sv
hdl/cf4_ctrl.sv
hdl/cf4_datapath.sv
hdl/cmap_format4_glyph_lookup_top.sv
test/cmap_format4_glyph_lookup_top_tb.sv
